@@ sv/line_edit_ring_buffer_macros.svh @@
// Assertion macros for the line_edit_ring_buffer RTL.
`ifndef LINE_EDIT_RING_BUFFER_MACROS_SVH
`define LINE_EDIT_RING_BUFFER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LERB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LERB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lerb_pkg.sv @@
package lerb_pkg;

    // Ring geometry
    localparam int DEPTH       = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int MAX_RESULTS = 31;
    localparam int REM_W       = $clog2(MAX_RESULTS + 1);
    localparam int COUNT_W     = 5;
    localparam int HELD_W      = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

    // Character codes
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef enum logic [1:0] {
        CMD_RECV  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD
    } state_t;

endpackage

@@ sv/lerb_ram.sv @@
module lerb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/line_edit_ring_buffer.sv @@
// Receive and clear commands keep s_tready high, so they run back to back.
// Read-out: each held byte takes a RAM fetch, then an output register load,
// and the load waits while the master side stalls; input is held off until the final
// result is loaded. An empty read skips the RAM fetch and gives a single result.
// Reset (rst_n low, asynchronous) empties the ring and drops any pending
// result; the byte RAM is not cleared.
`include "line_edit_ring_buffer_macros.svh"

module line_edit_ring_buffer
    import lerb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [12:8] stored_count, [15:13] zero
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] empty_res
);

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    state_t state_reg, state_next;

    logic [IDX_W-1:0]   write_index_reg, write_index_next;
    logic [IDX_W-1:0]   oldest_index_reg, oldest_index_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               empty_reg, empty_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_data_reg, out_data_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;

    cmd_t               cmd;
    logic               accept;
    logic               is_eol;
    logic               is_del;
    logic [IDX_W-1:0]   held;
    logic [HELD_W-1:0]  held_ext;
    logic [REM_W-1:0]   emit;
    logic [IDX_W-1:0]   wr_inc;
    logic               fin;
    logic               load_out;
    logic               ram_rd_en;
    logic               ram_wr_en;
    logic [7:0]         ram_wr_data;
    logic [7:0]         ram_rd_data;

    // Input decode
    assign cmd    = cmd_t'(s_tuser);
    assign accept = s_tvalid && s_tready;
    assign is_eol = (s_tdata == CH_CR) || (s_tdata == CH_LF);
    assign is_del = (s_tdata == CH_DEL);

    // Held count and read-out length
    assign held = (write_index_reg >= oldest_index_reg)
                ? write_index_reg - oldest_index_reg
                : IDX_W'(DEPTH) - oldest_index_reg + write_index_reg;
    assign held_ext = HELD_W'(held);
    assign emit = (held_ext > HELD_W'(MAX_RESULTS)) ? REM_W'(MAX_RESULTS)
                                                    : REM_W'(held_ext);

    assign wr_inc = next_slot(write_index_reg);
    assign fin    = empty_reg || (rem_reg == REM_W'(1));

    // Byte store
    assign ram_wr_en   = accept && (cmd == CMD_RECV) && !is_del;
    assign ram_wr_data = is_eol ? CH_NUL : s_tdata;

    lerb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (write_index_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (pos_reg),
        .rd_data (ram_rd_data)
    );

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_READ))
                begin
                    state_next = (held == '0) ? ST_LOAD : ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (load_out)
                begin
                    state_next = fin ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        s_tready  = 1'b0;
        ram_rd_en = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_FETCH:
            begin
                ram_rd_en = 1'b1;
            end
            ST_LOAD:
            begin
                load_out = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Index and read-out bookkeeping
    always_comb
    begin
        write_index_next  = write_index_reg;
        oldest_index_next = oldest_index_reg;
        pos_next          = pos_reg;
        rem_next          = rem_reg;
        empty_next        = empty_reg;
        cnt_next          = cnt_reg;

        if (accept)
        begin
            unique case (cmd)
                CMD_RECV:
                begin
                    if (is_del)
                    begin
                        // delete newest, ignored on empty ring
                        if (held != '0)
                        begin
                            write_index_next = (write_index_reg == '0)
                                             ? IDX_W'(DEPTH - 1)
                                             : write_index_reg - IDX_W'(1);
                        end
                    end
                    else
                    begin
                        // append, overwriting oldest when full
                        write_index_next = wr_inc;
                        if (wr_inc == oldest_index_reg)
                        begin
                            oldest_index_next = next_slot(oldest_index_reg);
                        end
                    end
                end
                CMD_READ:
                begin
                    pos_next   = oldest_index_reg;
                    rem_next   = emit;
                    empty_next = (held == '0);
                    cnt_next   = held_ext[COUNT_W-1:0];
                end
                CMD_CLEAR:
                begin
                    write_index_next  = '0;
                    oldest_index_next = '0;
                end
                default:
                begin
                    write_index_next = write_index_reg;
                end
            endcase
        end

        if (ram_rd_en)
        begin
            pos_next = next_slot(pos_reg);
        end

        if (load_out && !empty_reg)
        begin
            rem_next = rem_reg - REM_W'(1);
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = empty_reg ? CH_NUL : ram_rd_data;
            out_count_next = cnt_reg;
            out_last_next  = fin;
            out_empty_next = empty_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            write_index_reg  <= '0;
            oldest_index_reg <= '0;
            pos_reg          <= '0;
            rem_reg          <= '0;
            empty_reg        <= 1'b0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            write_index_reg  <= write_index_next;
            oldest_index_reg <= oldest_index_next;
            pos_reg          <= pos_next;
            rem_reg          <= rem_next;
            empty_reg        <= empty_next;
            cnt_reg          <= cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_data_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

    // Checks
    `LERB_ASSERT_NEXT(a_idx_hold_in_read, state_reg != ST_IDLE,
        $stable(write_index_reg) && $stable(oldest_index_reg),
        "ring indices changed during read-out")
    `LERB_ASSERT_NOW(a_load_has_work, state_reg == ST_LOAD,
        empty_reg || (rem_reg != '0),
        "read-out load with no bytes left")
    `LERB_ASSERT_NOW(a_empty_result, out_valid_reg && out_empty_reg,
        out_last_reg && (out_count_reg == '0) && (out_data_reg == CH_NUL),
        "malformed empty result")
    `LERB_ASSERT_NOW(a_idx_range, 1'b1,
        (write_index_reg <= IDX_W'(DEPTH - 1)) && (oldest_index_reg <= IDX_W'(DEPTH - 1)),
        "ring index out of range")

endmodule
